[rtl/bcpr_pkg.sv]
// Shared types and constants for the Pascal-row binomial coefficient block.
package bcpr_pkg;

    localparam int IDX_W  = 6;   // width of n, r and row indexes
    localparam int COEF_W = 31;  // width of a row entry / coefficient

    localparam logic [COEF_W-1:0] COEF_ZERO     = '0;
    localparam logic [COEF_W-1:0] COEF_ONE      = COEF_W'(1);
    localparam logic [COEF_W-1:0] COEF_ALL_ONES = '1;

    // Row memory access for one cycle.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [COEF_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

[rtl/bcpr_if.sv]
// Valid/ready channel interfaces for operand and coefficient transactions.
interface bcpr_in_if;
    logic                      valid;
    logic                      ready;
    logic [bcpr_pkg::IDX_W-1:0] n_value;
    logic [bcpr_pkg::IDX_W-1:0] r_value;

    modport source (output valid, output n_value, output r_value, input ready);
    modport sink   (input valid, input n_value, input r_value, output ready);
endinterface

interface bcpr_out_if;
    logic                       valid;
    logic                       ready;
    logic [bcpr_pkg::COEF_W-1:0] coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

[rtl/binomial_coefficient_pascal_row.sv]
// Binomial coefficient C(n,r) by in-place Pascal row update in a row memory.
//
// Usage:
//   i_in  : operand transactions (n_value, r_value), valid/ready.
//   o_out : coefficient transactions, valid/ready, one per operand.
//   One operand is processed at a time. r > n gives 0, n above MAX_N gives
//   all ones, r = 0 gives 1, each set on acceptance. Otherwise the sequencer
//   walks rows i = 1..n: it reads entry min(i,r) and the one below it, then
//   updates entries top down to 1; it finishes by reading entry r as the result.
//   The pace is set by the single read port of the row memory: one entry
//   is read and one written back per cycle.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and empties
//   the output register; the row memory needs no clearing since each entry is
//   written in an item before its read value is used.
//   When the receiver stalls, the result sits in the output register and the
//   next finished result waits in the sequencer; a new operand is taken once the
//   finished result has moved to the output register.
module binomial_coefficient_pascal_row #(
    parameter int MAX_N = 33
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcpr_in_if.sink    i_in,
    bcpr_out_if.source o_out
);
    bcpr_pkg::t_mem_req          w_mem_req;
    logic [bcpr_pkg::COEF_W-1:0] w_rdata;
    logic                        w_res_valid;
    logic [bcpr_pkg::COEF_W-1:0] w_res;
    logic                        w_res_take;
    logic                        w_in_ready;
    logic                        r_out_valid;
    logic [bcpr_pkg::COEF_W-1:0] r_out_coef;

    // row store, entries 0..MAX_N
    bcpr_row_mem #(
        .DEPTH (MAX_N + 1)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    bcpr_ctrl #(
        .MAX_N (MAX_N)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_n_value   (i_in.n_value),
        .i_r_value   (i_in.r_value),
        .o_in_ready  (w_in_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_mem_req   (w_mem_req),
        .i_rdata     (w_rdata)
    );

    assign i_in.ready = w_in_ready;

    // output register: loads when empty or being drained this cycle
    assign w_res_take = w_res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_take) begin
            r_out_coef <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.coefficient = r_out_coef;

    // sequencer never offers a result while taking a new operand
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_res_valid)
        else $error("operand ready while result pending");

    // the read and the write-back of one cycle never hit the same entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.we |-> (w_mem_req.waddr != w_mem_req.raddr))
        else $error("row read/write clash");

    // every Pascal entry written back is at least 1
    a_wdata_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.we |-> (w_mem_req.wdata != bcpr_pkg::COEF_ZERO))
        else $error("zero written to row");

    // a result handed over is in the output register next cycle
    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_take |=> (o_out.valid && (o_out.coefficient == $past(w_res))))
        else $error("result not captured");
endmodule

[rtl/bcpr_row_mem.sv]
// Pascal row store: one write port, one read port, registered read data.
module bcpr_row_mem #(
    parameter int DEPTH = 34
) (
    input  logic                          i_clk,
    input  bcpr_pkg::t_mem_req            i_req,
    output logic [bcpr_pkg::COEF_W-1:0]   o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bcpr_pkg::COEF_W-1:0] r_mem [DEPTH];
    logic [bcpr_pkg::COEF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bcpr_ctrl.sv]
// Row-update sequencer: walks rows 1..n, updating entries top down.
module bcpr_ctrl #(
    parameter int MAX_N = 33
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [bcpr_pkg::IDX_W-1:0]    i_n_value,
    input  logic [bcpr_pkg::IDX_W-1:0]    i_r_value,
    output logic                          o_in_ready,
    output logic                          o_res_valid,
    output logic [bcpr_pkg::COEF_W-1:0]   o_res,
    input  logic                          i_res_take,
    output bcpr_pkg::t_mem_req            o_mem_req,
    input  logic [bcpr_pkg::COEF_W-1:0]   i_rdata
);
    localparam logic [bcpr_pkg::IDX_W-1:0] MAX_N_IDX = bcpr_pkg::IDX_W'(MAX_N);
    localparam logic [bcpr_pkg::IDX_W-1:0] IDX_ONE   = bcpr_pkg::IDX_W'(1);
    localparam logic [bcpr_pkg::IDX_W-1:0] IDX_TWO   = bcpr_pkg::IDX_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_LOW,
        S_UPD,
        S_FIN,
        S_FIN_RD,
        S_HOLD
    } t_state;

    t_state                        r_state, n_state;
    logic [bcpr_pkg::IDX_W-1:0]    r_n, n_n;
    logic [bcpr_pkg::IDX_W-1:0]    r_r, n_r;
    logic [bcpr_pkg::IDX_W-1:0]    r_i, n_i;
    logic [bcpr_pkg::IDX_W-1:0]    r_j, n_j;
    logic [bcpr_pkg::COEF_W-1:0]   r_a, n_a;
    logic [bcpr_pkg::COEF_W-1:0]   r_res, n_res;
    logic [bcpr_pkg::COEF_W-1:0]   w_low;
    logic [bcpr_pkg::IDX_W-1:0]    w_top;
    bcpr_pkg::t_mem_req            w_req;

    // row[0] is always 1; it is never stored
    assign w_low = (r_j == IDX_ONE) ? bcpr_pkg::COEF_ONE : i_rdata;
    assign w_top = (r_i < r_r) ? r_i : r_r;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_r     = r_r;
        n_i     = r_i;
        n_j     = r_j;
        n_a     = r_a;
        n_res   = r_res;
        w_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n = i_n_value;
                    n_r = i_r_value;
                    n_i = IDX_ONE;
                    if (i_r_value > i_n_value) begin
                        n_res   = bcpr_pkg::COEF_ZERO;
                        n_state = S_HOLD;
                    end else if (i_n_value > MAX_N_IDX) begin
                        n_res   = bcpr_pkg::COEF_ALL_ONES;
                        n_state = S_HOLD;
                    end else if (i_r_value == '0) begin
                        n_res   = bcpr_pkg::COEF_ONE;
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_RD_TOP;
                    end
                end
            end
            S_RD_TOP: begin
                w_req.raddr = w_top;
                n_j         = w_top;
                n_state     = S_RD_LOW;
            end
            S_RD_LOW: begin
                // entry i is untouched in this item until row i: reads as zero
                n_a         = (r_j == r_i) ? bcpr_pkg::COEF_ZERO : i_rdata;
                w_req.raddr = r_j - IDX_ONE;
                n_state     = S_UPD;
            end
            S_UPD: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_a + w_low;
                n_a         = w_low;
                if (r_j == IDX_ONE) begin
                    if (r_i == r_n) begin
                        n_state = S_FIN;
                    end else begin
                        n_i     = r_i + IDX_ONE;
                        n_state = S_RD_TOP;
                    end
                end else begin
                    w_req.raddr = r_j - IDX_TWO;
                    n_j         = r_j - IDX_ONE;
                end
            end
            S_FIN: begin
                w_req.raddr = r_r;
                n_state     = S_FIN_RD;
            end
            S_FIN_RD: begin
                n_res   = i_rdata;
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n   <= n_n;
        r_r   <= n_r;
        r_i   <= n_i;
        r_j   <= n_j;
        r_a   <= n_a;
        r_res <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res       = r_res;
    assign o_mem_req   = w_req;
endmodule

[sim/binomial_coefficient_pascal_row_tb.sv]
// Self-checking testbench for the Pascal-row binomial coefficient block.
`timescale 1ns / 1ps

module binomial_coefficient_pascal_row_tb;

    localparam int MAX_N      = 33;
    localparam int CLK_PERIOD = 12;
    // Quiet window before the verdict, longer than the slowest item (n = r =
    // MAX_N), so that any stray transaction is caught.
    localparam int SETTLE_CYCLES = 800;
    localparam int RANDOM_ITEMS  = 1000;
    localparam logic [bcpr_pkg::IDX_W-1:0] N_MAX = bcpr_pkg::IDX_W'(MAX_N);

    // Operand pair with the coefficient predicted for it.
    typedef struct {
        logic [bcpr_pkg::IDX_W-1:0]  n_value;
        logic [bcpr_pkg::IDX_W-1:0]  r_value;
        logic [bcpr_pkg::COEF_W-1:0] coefficient;
    } t_coef_entry;

    logic i_clk;
    logic i_rst_n;

    bcpr_in_if  in_if ();
    bcpr_out_if out_if ();

    binomial_coefficient_pascal_row #(
        .MAX_N (MAX_N)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Coefficients still owed by the block, oldest first.
    t_coef_entry pending_coefs[$];
    int          error_count;
    // Chance in percent that a side idles on a given cycle.
    int          src_idle_pct;
    int          sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Generous fixed limit: well beyond 1000 worst-case items plus stalls.
    initial begin
        #60_000_000;
        $display("** binomial_coefficient_pascal_row: FAILED **");
        $finish;
    end

    // C(n,r) by growing one Pascal row in place, highest index first.
    // r above n gives zero; n above MAX_N (with r not above n) saturates.
    function automatic logic [bcpr_pkg::COEF_W-1:0] pascal_coef(
            input logic [bcpr_pkg::IDX_W-1:0] n,
            input logic [bcpr_pkg::IDX_W-1:0] r);
        logic [bcpr_pkg::COEF_W-1:0] row [0:MAX_N];
        int                          top;
        for (int k = 0; k <= MAX_N; k++) row[k] = bcpr_pkg::COEF_ZERO;
        row[0] = bcpr_pkg::COEF_ONE;
        if (r > n) return bcpr_pkg::COEF_ZERO;
        if (n > MAX_N) return bcpr_pkg::COEF_ALL_ONES;
        for (int i = 1; i <= n; i++) begin
            top = (i < r) ? i : r;
            for (int j = top; j > 0; j--) row[j] = row[j] + row[j-1];
        end
        return row[r];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    // Drive one operand transaction. Valid is left high after acceptance;
    // the next call either lowers it for a gap or presents the next pair,
    // so valid never sees two assignments in one time step.
    task automatic send_operand(input logic [bcpr_pkg::IDX_W-1:0] n,
                                input logic [bcpr_pkg::IDX_W-1:0] r);
        t_coef_entry entry;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.n_value <= n;
        in_if.r_value <= r;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        entry.n_value     = n;
        entry.r_value     = r;
        entry.coefficient = pascal_coef(n, r);
        pending_coefs.push_back(entry);
    endtask

    // Sender holds off until every owed coefficient has come back.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_coefs.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random ready, and a check of every coefficient transaction.
    // Outputs are sampled at the edge, before the block's updates land.
    initial begin
        t_coef_entry entry;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (pending_coefs.size() == 0) begin
                    report_mismatch($sformatf("unexpected coefficient %0d",
                                              out_if.coefficient));
                end else begin
                    entry = pending_coefs.pop_front();
                    if (out_if.coefficient !== entry.coefficient)
                        report_mismatch($sformatf("C(%0d,%0d): got %0d, expected %0d",
                                                  entry.n_value, entry.r_value,
                                                  out_if.coefficient, entry.coefficient));
                end
            end
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Edges of the index range and each special case: r above n, r at 0 or
    // at n, and n beyond MAX_N (saturated result).
    task automatic test_directed();
        send_operand(0, 0);
        send_operand(0, 1);
        send_operand(0, 63);
        send_operand(1, 0);
        send_operand(1, 1);
        send_operand(2, 1);
        send_operand(5, 6);
        send_operand(N_MAX, 0);
        send_operand(N_MAX, 1);
        send_operand(N_MAX, 16);
        send_operand(N_MAX, 17);
        send_operand(N_MAX, N_MAX - 1'b1);
        send_operand(N_MAX, N_MAX);
        send_operand(N_MAX, N_MAX + 1'b1);
        send_operand(N_MAX - 1'b1, N_MAX);
        send_operand(N_MAX + 1'b1, 0);
        send_operand(N_MAX + 1'b1, N_MAX + 1'b1);
        send_operand(40, 20);
        send_operand(63, 0);
        send_operand(63, 62);
        send_operand(63, 63);
        send_operand(42, 21);
        send_operand(21, 42);
        wait_drained();
    endtask

    // A short burst, a wait until the block is empty, then one more item.
    task automatic test_drain_pause();
        for (int k = 0; k < 8; k++)
            send_operand(bcpr_pkg::IDX_W'($urandom_range(MAX_N)),
                         bcpr_pkg::IDX_W'($urandom_range(63)));
        wait_drained();
        send_operand(N_MAX, 16);
        wait_drained();
    endtask

    // Mostly well-formed pairs (r up to n, n in range), then r above n,
    // saturating n, and fully random 6-bit fields so every bit toggles.
    task automatic send_random_operand();
        logic [bcpr_pkg::IDX_W-1:0] n;
        logic [bcpr_pkg::IDX_W-1:0] r;
        int                         kind;
        kind = $urandom_range(99);
        if (kind < 60) begin
            n = bcpr_pkg::IDX_W'($urandom_range(MAX_N));
            r = bcpr_pkg::IDX_W'($urandom_range(n));
        end else if (kind < 75) begin
            n = bcpr_pkg::IDX_W'($urandom_range(MAX_N));
            r = bcpr_pkg::IDX_W'($urandom_range(63, n + 1));
        end else if (kind < 85) begin
            n = bcpr_pkg::IDX_W'($urandom_range(63, MAX_N + 1));
            r = bcpr_pkg::IDX_W'($urandom_range(n));
        end else begin
            n = bcpr_pkg::IDX_W'($urandom);
            r = bcpr_pkg::IDX_W'($urandom);
        end
        send_operand(n, r);
    endtask

    task automatic test_random(input int items);
        for (int k = 0; k < items; k++) send_random_operand();
        wait_drained();
    endtask

    initial begin
        error_count   = 0;
        src_idle_pct  = 22;
        sink_idle_pct = 54;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.n_value <= '0;
        in_if.r_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();

        // Sender busy, receiver sparse.
        test_random(RANDOM_ITEMS / 3);

        // Sender sparse, receiver busy.
        src_idle_pct  = 54;
        sink_idle_pct = 22;
        test_random(RANDOM_ITEMS / 3);

        // Full throughput both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        // Quiet window: anything arriving now is unexpected.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_coefs.size() != 0)
            report_mismatch($sformatf("%0d coefficients never arrived",
                                      pending_coefs.size()));

        if (error_count == 0) begin
            $display("** binomial_coefficient_pascal_row: PASSED **");
        end else begin
            $display("** binomial_coefficient_pascal_row: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bcpr_pkg.sv
rtl/bcpr_if.sv
rtl/bcpr_row_mem.sv
rtl/bcpr_ctrl.sv
rtl/binomial_coefficient_pascal_row.sv
sim/binomial_coefficient_pascal_row_tb.sv
